// File: rtl/aba_pkg.sv
`default_nettype none

package aba_pkg;

    localparam int ALIGN       = 8;
    localparam int BASE_OFFSET = 64;
    localparam int OFFSET_BITS = 32;

    localparam int DATA_W  = 32;
    localparam int CMD_W   = 3;
    localparam int SHIFT_W = 5;
    localparam int WIDE_W  = DATA_W + 2;

    localparam logic [CMD_W-1:0] CMD_PUSH   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_POP    = 3'd1;
    localparam logic [CMD_W-1:0] CMD_POP_TO = 3'd2;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_INIT   = 3'd4;

    localparam logic CFG_REGION_SIZE  = 1'b0;
    localparam logic CFG_COMMIT_SHIFT = 1'b1;

    localparam logic [DATA_W-1:0]  REGION_SIZE_RESET  = 32'd16777216;
    localparam logic [SHIFT_W-1:0] COMMIT_SHIFT_RESET = 5'd16;
    localparam logic [DATA_W-1:0]  COMMIT_MARK_RESET  = 32'd65536;

    localparam logic [63:0] OFF_MAX = (64'd1 << OFFSET_BITS) - 64'd1;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [DATA_W-1:0] amount;
        logic              skip_zero;
    } cmd_word_t;

endpackage

`default_nettype wire

// File: rtl/arena_bump_allocator_top.sv
// Channel   Direction  Handshake            Payload
// input     in         in_valid / in_stall  command, amount, skip_zero
// result    out        out_valid/out_stall  block_offset, failed, zero_fill,
//                                           position, committed
// config    in         cfg_write            cfg_index, cfg_data
//
// One command per cycle sustained while out_stall is low; the result passes
// through the input register, then the result register. The offset
// and committed mark feed back through one align, add and compare in the
// result stage.
// Reset: offset at the base offset, committed mark 65536, region size
// 16777216, commit shift 16.
// A stalled result holds; one more command waits in the input register.
`default_nettype none

module arena_bump_allocator_top
(
    input  wire                         clk,
    input  wire                         rst_n,
    input  wire                         cfg_write,
    input  wire                         cfg_index,
    input  wire [aba_pkg::DATA_W-1:0]   cfg_data,
    input  wire                         in_valid,
    output logic                        in_stall,
    input  wire [aba_pkg::CMD_W-1:0]    command,
    input  wire [aba_pkg::DATA_W-1:0]   amount,
    input  wire                         skip_zero,
    output logic                        out_valid,
    input  wire                         out_stall,
    output logic [aba_pkg::DATA_W-1:0]  block_offset,
    output logic                        failed,
    output logic                        zero_fill,
    output logic [aba_pkg::DATA_W-1:0]  position,
    output logic [aba_pkg::DATA_W-1:0]  committed
);
    import aba_pkg::*;

    logic [DATA_W-1:0]  region_size_reg;
    logic [SHIFT_W-1:0] commit_shift_reg;

    logic [DATA_W-1:0]  offset_reg;
    logic [DATA_W-1:0]  commit_reg;
    logic [DATA_W-1:0]  offset_next;
    logic [DATA_W-1:0]  commit_next;

    logic               s1_valid_reg;
    cmd_word_t          s1_reg;

    logic               out_valid_reg;
    logic [DATA_W-1:0]  block_offset_reg;
    logic               failed_reg;
    logic               zero_fill_reg;
    logic [DATA_W-1:0]  block_offset_next;
    logic               failed_next;
    logic               zero_fill_next;

    logic               out_free;
    logic               advance;
    logic               load;

    logic [WIDE_W-1:0]  off_w;
    logic [WIDE_W-1:0]  base_w;
    logic [WIDE_W-1:0]  amt_w;
    logic [WIDE_W-1:0]  commit_w;
    logic [WIDE_W-1:0]  start_w;
    logic [WIDE_W-1:0]  end_w;
    logic [WIDE_W-1:0]  lim_w;
    logic [WIDE_W-1:0]  gran_w;
    logic [WIDE_W-1:0]  gmask_w;
    logic [WIDE_W-1:0]  round_w;
    logic [WIDE_W-1:0]  used_w;

    assign out_free = !out_valid_reg || !out_stall;
    assign advance  = s1_valid_reg && out_free;
    assign load     = !s1_valid_reg || advance;
    assign in_stall = s1_valid_reg && !out_free;

    // config
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            region_size_reg  <= REGION_SIZE_RESET;
            commit_shift_reg <= COMMIT_SHIFT_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_REGION_SIZE:  region_size_reg  <= cfg_data;
                CFG_COMMIT_SHIFT: commit_shift_reg <= cfg_data[SHIFT_W-1:0];
                default:          region_size_reg  <= region_size_reg;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (load)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (load && in_valid)
        begin
            s1_reg.command   <= command;
            s1_reg.amount    <= amount;
            s1_reg.skip_zero <= skip_zero;
        end
    end

    // result stage
    assign off_w    = WIDE_W'(offset_reg);
    assign base_w   = WIDE_W'(BASE_OFFSET);
    assign amt_w    = WIDE_W'(s1_reg.amount);
    assign commit_w = WIDE_W'(commit_reg);
    assign start_w  = ((off_w + WIDE_W'(ALIGN - 1)) / WIDE_W'(ALIGN)) * WIDE_W'(ALIGN);
    assign end_w    = start_w + amt_w;
    assign lim_w    = (64'(region_size_reg) < OFF_MAX) ? WIDE_W'(region_size_reg)
                                                       : WIDE_W'(OFF_MAX);
    assign gran_w   = (((WIDE_W'(1) << commit_shift_reg) + WIDE_W'(ALIGN - 1))
                       / WIDE_W'(ALIGN)) * WIDE_W'(ALIGN);
    assign gmask_w  = gran_w - WIDE_W'(1);
    assign round_w  = (end_w + gmask_w) & ~gmask_w;
    assign used_w   = (off_w > base_w) ? (off_w - base_w) : '0;

    always_comb
    begin
        offset_next       = offset_reg;
        commit_next       = commit_reg;
        block_offset_next = '0;
        failed_next       = 1'b0;
        zero_fill_next    = 1'b0;
        case (s1_reg.command)
            CMD_PUSH:
            begin
                if (end_w > lim_w)
                    failed_next = 1'b1;
                else
                begin
                    if (end_w > commit_w)
                        commit_next = (round_w < lim_w) ? round_w[DATA_W-1:0]
                                                        : lim_w[DATA_W-1:0];
                    offset_next       = end_w[DATA_W-1:0];
                    block_offset_next = start_w[DATA_W-1:0];
                    zero_fill_next    = !s1_reg.skip_zero;
                end
            end
            CMD_POP:
            begin
                offset_next = (amt_w < used_w) ? DATA_W'(off_w - amt_w)
                                               : DATA_W'(off_w - used_w);
            end
            CMD_POP_TO:
            begin
                if (amt_w < off_w)
                    offset_next = (amt_w > base_w) ? s1_reg.amount : DATA_W'(BASE_OFFSET);
            end
            CMD_CLEAR:
            begin
                if (off_w > base_w)
                    offset_next = DATA_W'(BASE_OFFSET);
            end
            CMD_INIT:
            begin
                offset_next = DATA_W'(BASE_OFFSET);
                commit_next = gran_w[DATA_W-1:0];
            end
            default:
            begin
                offset_next = offset_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg    <= DATA_W'(BASE_OFFSET);
            commit_reg    <= COMMIT_MARK_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                offset_reg <= offset_next;
                commit_reg <= commit_next;
            end
            if (out_free)
                out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            block_offset_reg <= block_offset_next;
            failed_reg       <= failed_next;
            zero_fill_reg    <= zero_fill_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign block_offset = block_offset_reg;
    assign failed       = failed_reg;
    assign zero_fill    = zero_fill_reg;
    assign position     = offset_reg;
    assign committed    = commit_reg;

    a_offset_floor: assert property (@(posedge clk) disable iff (!rst_n)
        offset_reg >= DATA_W'(BASE_OFFSET))
        else $error("offset below base");

    a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && failed_reg) |-> (block_offset_reg == '0 && !zero_fill_reg))
        else $error("failed push reports a block");

    a_fail_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && failed_next) |=> (offset_reg == $past(offset_reg)
                                      && commit_reg == $past(commit_reg)))
        else $error("failed push changed state");

    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && out_valid_reg))
        else $error("input stalled with room");

endmodule

`default_nettype wire
